// ----- sv/assert_macros.svh -----
// Assertion macros shared by the modules that check their own logic.
// Each macro uses the clock i_clk and the active-low reset i_rst_n of the
// module in which it stands.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIODE_ASSERT_IMPLY(label, cond, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SIODE_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ----- sv/siode_pkg.sv -----
package siode_pkg;

    // Fixed-point format of levels, rates and times.
    localparam int DataWidth     = 32;
    localparam int FracBits      = 16;
    localparam int TimeWidth     = 31;
    localparam int ProdWidth     = 2 * DataWidth;
    localparam int CfgIndexWidth = 3;

    localparam logic [TimeWidth-1:0] TimeMax   = '1;
    localparam logic [TimeWidth-1:0] StepReset = 31'd655;

    // floor(x / 3) equals the upper word of x * RecipThree for 0 <= x < 2^31.
    localparam logic [DataWidth-1:0] RecipThree = 32'h5555_5556;

    localparam logic signed [DataWidth-1:0] LevelMax = 32'sh7FFF_FFFF;
    localparam logic signed [DataWidth-1:0] LevelMin = 32'sh8000_0000;

    typedef logic signed [DataWidth-1:0] t_level;
    typedef logic [TimeWidth-1:0]        t_time;

    // Configuration register indexes.
    typedef enum logic [CfgIndexWidth-1:0] {
        REG_INFECTION = 3'd0,
        REG_RECOVERY  = 3'd1,
        REG_IMMUNITY  = 3'd2,
        REG_STEP      = 3'd3,
        REG_END       = 3'd4,
        REG_METHOD    = 3'd5
    } t_reg_index;

    typedef enum logic {
        OP_ADVANCE = 1'b0,
        OP_LOAD    = 1'b1
    } t_operation;

    typedef enum logic {
        METHOD_EULER = 1'b0,
        METHOD_RK4   = 1'b1
    } t_method;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SIXTH,
        ST_MUL_AI,
        ST_MUL_AIS,
        ST_MUL_BI,
        ST_MUL_CR,
        ST_KSUB,
        ST_UPD,
        ST_FIN,
        ST_TIME,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_time   rate_a;
        t_time   rate_b;
        t_time   rate_c;
        t_time   step;
        t_time   end_time;
        t_method method;
    } t_cfg;

    typedef struct packed {
        t_time  sample_time;
        t_level infected;
        t_level susceptible;
        t_level recovered;
        logic   finished;
        logic   saturated;
    } t_result;

    typedef struct packed {
        t_level               val;
        logic [DataWidth-1:0] hi;
        logic                 ovf;
    } t_mul_out;

    typedef struct packed {
        logic idle;
        logic done;
    } t_seq_status;

    typedef struct packed {
        logic   ovf;
        t_level val;
    } t_sat;

    // Saturating addition.
    function automatic t_sat sat_add(t_level a, t_level b);
        logic signed [DataWidth:0] s;
        t_sat r;
        s = {a[DataWidth-1], a} + {b[DataWidth-1], b};
        r.ovf = s[DataWidth] != s[DataWidth-1];
        r.val = r.ovf ? (s[DataWidth] ? LevelMin : LevelMax) : s[DataWidth-1:0];
        return r;
    endfunction

    // Saturating subtraction.
    function automatic t_sat sat_sub(t_level a, t_level b);
        logic signed [DataWidth:0] s;
        t_sat r;
        s = {a[DataWidth-1], a} - {b[DataWidth-1], b};
        r.ovf = s[DataWidth] != s[DataWidth-1];
        r.val = r.ovf ? (s[DataWidth] ? LevelMin : LevelMax) : s[DataWidth-1:0];
        return r;
    endfunction

    // Saturating doubling.
    function automatic t_sat sat_dbl(t_level a);
        t_sat r;
        r.ovf = a[DataWidth-1] != a[DataWidth-2];
        r.val = r.ovf ? (a[DataWidth-1] ? LevelMin : LevelMax) : {a[DataWidth-2:0], 1'b0};
        return r;
    endfunction

endpackage

// ----- sv/sirs_ode_integrator_step_unit.sv -----
// Channel   | Direction | Handshake                | Contents
// ----------+-----------+--------------------------+-----------------------------------------
// input     | in        | i_s_tvalid / o_s_tready  | tdata: infected, susceptible, recovered
//           |           |                          | tuser: operation (advance or load)
// result    | out       | o_m_tvalid / i_m_tready  | tdata: time, infected, susceptible,
//           |           |                          | recovered; tuser: finished, saturated
// config    | in        | i_cfg_valid / o_cfg_ready| index and write data, always accepted
//
// One shared 32x32 multiplier with two register stages does every product; each
// product holds the sequencer until its result has left both stages. A Runge-Kutta
// step runs four slope stages of seven products and a sum, then three final
// products; an Euler step runs one slope stage. A load goes straight to the result.
// The input is ready only while the sequencer is idle. A finished result waits in the
// sequencer until the output register is empty or being read. Reset is synchronous
// and clears state, configuration and valid flags.
`include "assert_macros.svh"

module sirs_ode_integrator_step_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [95:0]  i_s_tdata,   // [31:0] load_infected, [63:32] load_susceptible,
                                      // [95:64] load_recovered
    input  logic         i_s_tuser,   // [0] operation
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [127:0] o_m_tdata,   // [30:0] sample_time, [62:31] infected_out,
                                      // [94:63] susceptible_out, [126:95] recovered_out
    output logic [1:0]   o_m_tuser,   // [0] finished, [1] saturated
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [siode_pkg::CfgIndexWidth-1:0] i_cfg_index,
    input  logic [siode_pkg::DataWidth-1:0]     i_cfg_data
);

    siode_pkg::t_cfg        r_cfg;
    logic                   r_m_valid;
    siode_pkg::t_result     r_m_result;
    siode_pkg::t_seq_status w_status;
    siode_pkg::t_result     w_result;
    logic                   w_in_accept;
    logic                   w_out_free;

    // Handshakes.
    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = w_status.idle;
    assign w_in_accept = i_s_tvalid && o_s_tready;
    assign w_out_free  = !r_m_valid || i_m_tready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_a   <= '0;
            r_cfg.rate_b   <= '0;
            r_cfg.rate_c   <= '0;
            r_cfg.step     <= siode_pkg::StepReset;
            r_cfg.end_time <= '0;
            r_cfg.method   <= siode_pkg::METHOD_EULER;
        end else if (i_cfg_valid) begin
            unique case (siode_pkg::t_reg_index'(i_cfg_index))
                siode_pkg::REG_INFECTION: r_cfg.rate_a   <= i_cfg_data[30:0];
                siode_pkg::REG_RECOVERY:  r_cfg.rate_b   <= i_cfg_data[30:0];
                siode_pkg::REG_IMMUNITY:  r_cfg.rate_c   <= i_cfg_data[30:0];
                siode_pkg::REG_STEP:      r_cfg.step     <= i_cfg_data[30:0];
                siode_pkg::REG_END:       r_cfg.end_time <= i_cfg_data[30:0];
                siode_pkg::REG_METHOD:    r_cfg.method   <= siode_pkg::t_method'(i_cfg_data[0]);
                default:                  r_cfg          <= r_cfg;
            endcase
        end
    end

    siode_seq u_seq (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (w_in_accept),
        .i_operation        (siode_pkg::t_operation'(i_s_tuser)),
        .i_load_infected    (i_s_tdata[31:0]),
        .i_load_susceptible (i_s_tdata[63:32]),
        .i_load_recovered   (i_s_tdata[95:64]),
        .i_cfg              (r_cfg),
        .i_out_free         (w_out_free),
        .o_status           (w_status),
        .o_result           (w_result)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_status.done && w_out_free) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_status.done && w_out_free) begin
            r_m_result <= w_result;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {1'b0, r_m_result.recovered, r_m_result.susceptible,
                         r_m_result.infected, r_m_result.sample_time};
    assign o_m_tuser  = {r_m_result.saturated, r_m_result.finished};

    // An accepted transaction keeps the sequencer busy in the next cycle.
    `SIODE_ASSERT_NEXT(a_busy_after_accept, w_in_accept, !o_s_tready, "accepted while busy")
    // A finished result handed over appears in the output register.
    `SIODE_ASSERT_NEXT(a_result_loaded, w_status.done && w_out_free, r_m_valid,
        "result lost on handover")
    // No new input while a result is still held by the sequencer.
    `SIODE_ASSERT_IMPLY(a_no_accept_when_done, w_status.done, !o_s_tready,
        "input ready with result pending")

endmodule

// ----- sv/siode_mul.sv -----
module siode_mul (
    input  logic               i_clk,
    input  siode_pkg::t_level  i_op_a,
    input  siode_pkg::t_level  i_op_b,
    output siode_pkg::t_mul_out o_res
);

    logic signed [siode_pkg::ProdWidth-1:0] r_prod;
    siode_pkg::t_mul_out                    r_out;
    siode_pkg::t_mul_out                    n_out;
    logic                                   w_fits;

    // First stage: the exact signed product.
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_op_a) * 64'(i_op_b);
    end

    // Second stage: drop the fraction (floor) and saturate to the level range.
    assign w_fits = (&r_prod[63:47]) || !(|r_prod[63:47]);

    always_comb begin
        n_out.hi  = r_prod[63:32];
        n_out.ovf = !w_fits;
        if (w_fits) begin
            n_out.val = r_prod[47:16];
        end else begin
            n_out.val = r_prod[63] ? siode_pkg::LevelMin : siode_pkg::LevelMax;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_res = r_out;

endmodule

// ----- sv/siode_seq.sv -----
module siode_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  siode_pkg::t_operation i_operation,
    input  siode_pkg::t_level     i_load_infected,
    input  siode_pkg::t_level     i_load_susceptible,
    input  siode_pkg::t_level     i_load_recovered,
    input  siode_pkg::t_cfg       i_cfg,
    input  logic                  i_out_free,
    output siode_pkg::t_seq_status o_status,
    output siode_pkg::t_result    o_result
);

    siode_pkg::t_state   r_state;
    siode_pkg::t_state   n_state;
    logic [1:0]          r_ph;
    logic [1:0]          r_idx;
    logic [1:0]          r_stage;

    siode_pkg::t_level   r_y   [3];
    siode_pkg::t_level   r_t   [3];
    siode_pkg::t_level   r_k   [3];
    siode_pkg::t_level   r_acc [3];
    siode_pkg::t_level   r_p;
    siode_pkg::t_level   r_ais;
    siode_pkg::t_level   r_bi;
    siode_pkg::t_level   r_cr;
    siode_pkg::t_time    r_sixth;
    siode_pkg::t_time    r_time;
    logic                r_sat;
    siode_pkg::t_result  r_res;

    siode_pkg::t_level   w_op_a;
    siode_pkg::t_level   w_op_b;
    siode_pkg::t_mul_out w_mul;
    siode_pkg::t_level   w_v   [3];
    siode_pkg::t_level   w_inc;
    siode_pkg::t_level   w_half;
    siode_pkg::t_sat     w_k   [3];
    siode_pkg::t_sat     w_dbl [3];
    siode_pkg::t_sat     w_acc [3];
    siode_pkg::t_sat     w_upd;
    logic [siode_pkg::TimeWidth:0] w_tsum;
    siode_pkg::t_time    w_tnext;
    logic                w_mul_last;

    siode_mul u_mul (
        .i_clk  (i_clk),
        .i_op_a (w_op_a),
        .i_op_b (w_op_b),
        .o_res  (w_mul)
    );

    // Operand selection: the current stage reads the state or the trial point.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_v[i] = (r_stage == 2'd0) ? r_y[i] : r_t[i];
        end
        w_half = {2'b00, i_cfg.step[siode_pkg::TimeWidth-1:1]};
        if (i_cfg.method == siode_pkg::METHOD_RK4 && r_stage < 2'd2) begin
            w_inc = w_half;
        end else begin
            w_inc = {1'b0, i_cfg.step};
        end
    end

    // Slope terms, the weighted slope sum, the level update and the next time.
    always_comb begin
        w_k[0] = siode_pkg::sat_sub(r_ais, r_bi);
        w_k[1] = siode_pkg::sat_sub(r_cr, r_ais);
        w_k[2] = siode_pkg::sat_sub(r_bi, r_cr);
        for (int i = 0; i < 3; i++) begin
            w_dbl[i] = siode_pkg::sat_dbl(r_k[i]);
            if (r_stage == 2'd3) begin
                w_acc[i] = siode_pkg::sat_add(r_acc[i], r_k[i]);
            end else begin
                w_acc[i] = siode_pkg::sat_add(r_acc[i], w_dbl[i].val);
            end
        end
        w_upd  = siode_pkg::sat_add(r_y[r_idx], w_mul.val);
        w_tsum = {1'b0, r_time} + {1'b0, i_cfg.step};
        w_tnext = w_tsum[siode_pkg::TimeWidth] ? siode_pkg::TimeMax
                                                : w_tsum[siode_pkg::TimeWidth-1:0];
        w_mul_last = r_ph == 2'd2;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            siode_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = (i_operation == siode_pkg::OP_LOAD) ? siode_pkg::ST_DONE
                                                                   : siode_pkg::ST_SIXTH;
                end
            end
            siode_pkg::ST_SIXTH:   if (w_mul_last) n_state = siode_pkg::ST_MUL_AI;
            siode_pkg::ST_MUL_AI:  if (w_mul_last) n_state = siode_pkg::ST_MUL_AIS;
            siode_pkg::ST_MUL_AIS: if (w_mul_last) n_state = siode_pkg::ST_MUL_BI;
            siode_pkg::ST_MUL_BI:  if (w_mul_last) n_state = siode_pkg::ST_MUL_CR;
            siode_pkg::ST_MUL_CR:  if (w_mul_last) n_state = siode_pkg::ST_KSUB;
            siode_pkg::ST_KSUB:    n_state = siode_pkg::ST_UPD;
            siode_pkg::ST_UPD: begin
                if (w_mul_last && r_idx == 2'd2) begin
                    if (i_cfg.method == siode_pkg::METHOD_EULER) begin
                        n_state = siode_pkg::ST_TIME;
                    end else if (r_stage == 2'd3) begin
                        n_state = siode_pkg::ST_FIN;
                    end else begin
                        n_state = siode_pkg::ST_MUL_AI;
                    end
                end
            end
            siode_pkg::ST_FIN: begin
                if (w_mul_last && r_idx == 2'd2) n_state = siode_pkg::ST_TIME;
            end
            siode_pkg::ST_TIME:    n_state = siode_pkg::ST_DONE;
            siode_pkg::ST_DONE:    if (i_out_free) n_state = siode_pkg::ST_IDLE;
            default:               n_state = siode_pkg::ST_IDLE;
        endcase
    end

    // Outputs: multiplier operands and status.
    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        unique case (r_state)
            siode_pkg::ST_SIXTH: begin
                w_op_a = w_half;
                w_op_b = siode_pkg::RecipThree;
            end
            siode_pkg::ST_MUL_AI: begin
                w_op_a = {1'b0, i_cfg.rate_a};
                w_op_b = w_v[0];
            end
            siode_pkg::ST_MUL_AIS: begin
                w_op_a = r_p;
                w_op_b = w_v[1];
            end
            siode_pkg::ST_MUL_BI: begin
                w_op_a = {1'b0, i_cfg.rate_b};
                w_op_b = w_v[0];
            end
            siode_pkg::ST_MUL_CR: begin
                w_op_a = w_v[2];
                w_op_b = {1'b0, i_cfg.rate_c};
            end
            siode_pkg::ST_UPD: begin
                w_op_a = r_k[r_idx];
                w_op_b = w_inc;
            end
            siode_pkg::ST_FIN: begin
                w_op_a = {1'b0, r_sixth};
                w_op_b = r_acc[r_idx];
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
        o_status.idle = r_state == siode_pkg::ST_IDLE;
        o_status.done = r_state == siode_pkg::ST_DONE;
    end

    // Sequencer counters and the integrator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= siode_pkg::ST_IDLE;
            r_ph    <= '0;
            r_idx   <= '0;
            r_stage <= '0;
            r_time  <= '0;
            r_sat   <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_y[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            unique case (r_state)
                siode_pkg::ST_IDLE: begin
                    r_ph    <= '0;
                    r_idx   <= '0;
                    r_stage <= '0;
                    r_sat   <= 1'b0;
                    if (i_start && i_operation == siode_pkg::OP_LOAD) begin
                        r_y[0] <= i_load_infected;
                        r_y[1] <= i_load_susceptible;
                        r_y[2] <= i_load_recovered;
                        r_time <= '0;
                    end
                end
                siode_pkg::ST_SIXTH, siode_pkg::ST_MUL_AI, siode_pkg::ST_MUL_AIS,
                siode_pkg::ST_MUL_BI, siode_pkg::ST_MUL_CR: begin
                    r_ph <= w_mul_last ? 2'd0 : r_ph + 2'd1;
                    if (w_mul_last && r_state != siode_pkg::ST_SIXTH) begin
                        r_sat <= r_sat | w_mul.ovf;
                    end
                end
                siode_pkg::ST_KSUB: begin
                    r_sat <= r_sat | w_k[0].ovf | w_k[1].ovf | w_k[2].ovf;
                    r_idx <= '0;
                end
                siode_pkg::ST_UPD: begin
                    r_ph <= w_mul_last ? 2'd0 : r_ph + 2'd1;
                    // The slope sum takes this stage's slopes once, at the start.
                    if (r_idx == 2'd0 && r_ph == 2'd0 && r_stage != 2'd0) begin
                        r_sat <= r_sat | w_acc[0].ovf | w_acc[1].ovf | w_acc[2].ovf
                                 | (r_stage != 2'd3 &&
                                    (w_dbl[0].ovf || w_dbl[1].ovf || w_dbl[2].ovf));
                    end
                    if (w_mul_last) begin
                        r_sat <= r_sat | w_mul.ovf | w_upd.ovf;
                        if (r_idx == 2'd2) begin
                            r_idx   <= '0;
                            r_stage <= r_stage + 2'd1;
                            if (i_cfg.method == siode_pkg::METHOD_EULER) begin
                                r_y[0] <= r_t[0];
                                r_y[1] <= r_t[1];
                                r_y[2] <= w_upd.val;
                            end
                        end else begin
                            r_idx <= r_idx + 2'd1;
                        end
                    end
                end
                siode_pkg::ST_FIN: begin
                    r_ph <= w_mul_last ? 2'd0 : r_ph + 2'd1;
                    if (w_mul_last) begin
                        r_sat      <= r_sat | w_mul.ovf | w_upd.ovf;
                        r_y[r_idx] <= w_upd.val;
                        r_idx      <= r_idx + 2'd1;
                    end
                end
                siode_pkg::ST_TIME: begin
                    r_time <= w_tnext;
                end
                siode_pkg::ST_DONE: begin
                    r_ph <= '0;
                end
                default: begin
                    r_ph <= '0;
                end
            endcase
        end
    end

    // Working values and the reported result.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            siode_pkg::ST_IDLE: begin
                if (i_start) begin
                    r_res.finished  <= 1'b0;
                    r_res.saturated <= 1'b0;
                    if (i_operation == siode_pkg::OP_LOAD) begin
                        r_res.sample_time <= '0;
                        r_res.infected    <= i_load_infected;
                        r_res.susceptible <= i_load_susceptible;
                        r_res.recovered   <= i_load_recovered;
                    end else begin
                        r_res.sample_time <= r_time;
                        r_res.infected    <= r_y[0];
                        r_res.susceptible <= r_y[1];
                        r_res.recovered   <= r_y[2];
                    end
                end
            end
            siode_pkg::ST_SIXTH:   if (w_mul_last) r_sixth <= w_mul.hi[siode_pkg::TimeWidth-1:0];
            siode_pkg::ST_MUL_AI:  if (w_mul_last) r_p     <= w_mul.val;
            siode_pkg::ST_MUL_AIS: if (w_mul_last) r_ais   <= w_mul.val;
            siode_pkg::ST_MUL_BI:  if (w_mul_last) r_bi    <= w_mul.val;
            siode_pkg::ST_MUL_CR:  if (w_mul_last) r_cr    <= w_mul.val;
            siode_pkg::ST_KSUB: begin
                for (int i = 0; i < 3; i++) begin
                    r_k[i] <= w_k[i].val;
                end
            end
            siode_pkg::ST_UPD: begin
                if (r_idx == 2'd0 && r_ph == 2'd0) begin
                    for (int i = 0; i < 3; i++) begin
                        r_acc[i] <= (r_stage == 2'd0) ? r_k[i] : w_acc[i].val;
                    end
                end
                if (w_mul_last) begin
                    r_t[r_idx] <= w_upd.val;
                end
            end
            siode_pkg::ST_TIME: begin
                r_res.finished  <= w_tnext >= i_cfg.end_time;
                r_res.saturated <= r_sat | w_tsum[siode_pkg::TimeWidth];
            end
            default: begin
                r_res <= r_res;
            end
        endcase
    end

    assign o_result = r_res;

endmodule

// ----- tb/tb_sirs_ode_integrator_step_unit.sv -----
`timescale 1ns / 1ps

module tb_sirs_ode_integrator_step_unit;

    typedef struct {
        siode_pkg::t_operation op;
        logic [95:0]           levels;
    } t_epi_item;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [95:0]  i_s_tdata;
    logic         i_s_tuser;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [127:0] o_m_tdata;
    logic [1:0]   o_m_tuser;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [siode_pkg::CfgIndexWidth-1:0] i_cfg_index;
    logic [siode_pkg::DataWidth-1:0]     i_cfg_data;

    t_epi_item           pending_items[$];
    siode_pkg::t_result  expected_samples[$];
    int                  fail_count;
    int                  idle_mode;

    // Shadow of the configuration and the integrator state.
    longint rate_a, rate_b, rate_c, step_len, end_len;
    bit     use_rk4;
    longint clock_now;
    longint lvl[3];
    bit     sat_seen;

    sirs_ode_integrator_step_unit u_dut (.*);

    // Clock generation.
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic longint clamp_level(longint v);
        if (v > 64'sh7FFF_FFFF) begin
            sat_seen = 1'b1;
            return 64'sh7FFF_FFFF;
        end
        if (v < -64'sh8000_0000) begin
            sat_seen = 1'b1;
            return -64'sh8000_0000;
        end
        return v;
    endfunction

    // Fixed-point product, floored then saturated.
    function automatic longint fx_mul(longint x, longint y);
        return clamp_level((x * y) >>> siode_pkg::FracBits);
    endfunction

    function automatic void slopes(input longint y[3], output longint f[3]);
        longint ais, bi, cr;
        ais  = fx_mul(fx_mul(rate_a, y[0]), y[1]);
        bi   = fx_mul(rate_b, y[0]);
        cr   = fx_mul(y[2], rate_c);
        f[0] = clamp_level(ais - bi);
        f[1] = clamp_level(cr - ais);
        f[2] = clamp_level(bi - cr);
    endfunction

    // Work out the sample reported for one accepted item and advance the shadow state.
    function automatic siode_pkg::t_result integrate_item(siode_pkg::t_operation op,
                                                          logic [95:0] d);
        siode_pkg::t_result r;
        longint k[4][3];
        longint tmp[3];
        longint yn[3];
        longint f[3];
        longint inc, s;
        sat_seen = 1'b0;
        if (op == siode_pkg::OP_LOAD) begin
            for (int i = 0; i < 3; i++)
                lvl[i] = clamp_level(longint'($signed(d[32*i +: 32])));
            clock_now = 0;
        end
        r.sample_time = siode_pkg::t_time'(clock_now);
        r.infected    = siode_pkg::t_level'(lvl[0]);
        r.susceptible = siode_pkg::t_level'(lvl[1]);
        r.recovered   = siode_pkg::t_level'(lvl[2]);
        if (op == siode_pkg::OP_LOAD) begin
            r.finished  = 1'b0;
            r.saturated = sat_seen;
            return r;
        end
        if (use_rk4) begin
            for (int j = 0; j < 4; j++) begin
                inc = (j < 2) ? step_len / 2 : step_len;
                if (j == 0)
                    slopes(lvl, f);
                else
                    slopes(tmp, f);
                for (int i = 0; i < 3; i++) begin
                    k[j][i] = f[i];
                    tmp[i]  = clamp_level(lvl[i] + fx_mul(f[i], inc));
                end
            end
            for (int i = 0; i < 3; i++) begin
                s = clamp_level(k[0][i] + clamp_level(k[1][i] + k[1][i]));
                s = clamp_level(s + clamp_level(k[2][i] + k[2][i]));
                s = clamp_level(s + k[3][i]);
                yn[i] = clamp_level(lvl[i] + fx_mul(step_len / 6, s));
            end
        end else begin
            slopes(lvl, f);
            for (int i = 0; i < 3; i++)
                yn[i] = clamp_level(lvl[i] + fx_mul(step_len, f[i]));
        end
        lvl = yn;
        clock_now += step_len;
        if (clock_now > longint'(siode_pkg::TimeMax)) begin
            clock_now = siode_pkg::TimeMax;
            sat_seen  = 1'b1;
        end
        r.finished  = clock_now >= end_len;
        r.saturated = sat_seen;
        return r;
    endfunction

    // Input driver: predicts on each accepted transaction and offers the next item.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= '0;
            i_s_tuser  <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                expected_samples.push_back(
                    integrate_item(siode_pkg::t_operation'(i_s_tuser), i_s_tdata));
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_items.size() > 0 &&
                    $urandom_range(99) >= (idle_mode == 0 ? 10 : idle_mode == 1 ? 52 : 0)) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= pending_items[0].levels;
                    i_s_tuser  <= pending_items[0].op;
                    void'(pending_items.pop_front());
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge i_clk) begin
        siode_pkg::t_result want;
        siode_pkg::t_result got;
        i_m_tready <= $urandom_range(99) >= (idle_mode == 0 ? 52 : idle_mode == 1 ? 10 : 0);
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.sample_time = o_m_tdata[30:0];
            got.infected    = o_m_tdata[62:31];
            got.susceptible = o_m_tdata[94:63];
            got.recovered   = o_m_tdata[126:95];
            got.finished    = o_m_tuser[0];
            got.saturated   = o_m_tuser[1];
            if (expected_samples.size() == 0) begin
                $error("unexpected result transaction");
                fail_count++;
            end else begin
                want = expected_samples.pop_front();
                if (got.sample_time !== want.sample_time) begin
                    $error("sample_time: expected %0d, got %0d", want.sample_time,
                           got.sample_time);
                    fail_count++;
                end
                if (got.infected !== want.infected) begin
                    $error("infected_out: expected %0d, got %0d", want.infected, got.infected);
                    fail_count++;
                end
                if (got.susceptible !== want.susceptible) begin
                    $error("susceptible_out: expected %0d, got %0d", want.susceptible,
                           got.susceptible);
                    fail_count++;
                end
                if (got.recovered !== want.recovered) begin
                    $error("recovered_out: expected %0d, got %0d", want.recovered,
                           got.recovered);
                    fail_count++;
                end
                if (got.finished !== want.finished) begin
                    $error("finished: expected %0d, got %0d", want.finished, got.finished);
                    fail_count++;
                end
                if (got.saturated !== want.saturated) begin
                    $error("saturated: expected %0d, got %0d", want.saturated, got.saturated);
                    fail_count++;
                end
            end
        end
    end

    // Offers one register write and returns at the edge that accepts it; the caller
    // drops the valid after its last write.
    task automatic write_reg(siode_pkg::t_reg_index idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            siode_pkg::REG_INFECTION: rate_a   = val[30:0];
            siode_pkg::REG_RECOVERY:  rate_b   = val[30:0];
            siode_pkg::REG_IMMUNITY:  rate_c   = val[30:0];
            siode_pkg::REG_STEP:      step_len = val[30:0];
            siode_pkg::REG_END:       end_len  = val[30:0];
            siode_pkg::REG_METHOD:    use_rk4  = val[0];
            default: ;
        endcase
    endtask

    // Wait until every sample has come back, then let the sequencer settle.
    task automatic drain();
        while (pending_items.size() > 0 || expected_samples.size() > 0 || i_s_tvalid)
            @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic run_trajectory(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                  logic [31:0] h, logic [31:0] t_end, logic rk4,
                                  logic [95:0] start, int n_steps);
        t_epi_item it;
        write_reg(siode_pkg::REG_INFECTION, a);
        write_reg(siode_pkg::REG_RECOVERY, b);
        write_reg(siode_pkg::REG_IMMUNITY, c);
        write_reg(siode_pkg::REG_STEP, h);
        write_reg(siode_pkg::REG_END, t_end);
        write_reg(siode_pkg::REG_METHOD, {31'b0, rk4});
        i_cfg_valid <= 1'b0;
        it.op     = siode_pkg::OP_LOAD;
        it.levels = start;
        pending_items.push_back(it);
        for (int n = 0; n < n_steps; n++) begin
            // Level bits are ignored on an advance, so they carry random noise.
            it.op     = siode_pkg::OP_ADVANCE;
            it.levels = {$urandom, $urandom, $urandom};
            pending_items.push_back(it);
        end
        drain();
    endtask

    function automatic logic [31:0] pick_rate();
        case ($urandom_range(9))
            0:       return 0;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom & 32'h7FFF_FFFF;
            default: return $urandom_range(32'h0002_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_level();
        if ($urandom_range(4) == 0)
            return $urandom;
        return $urandom_range(32'h000A_0000);
    endfunction

    initial begin
        logic [31:0] h;
        fail_count  = 0;
        idle_mode   = 0;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        rate_a = 0; rate_b = 0; rate_c = 0;
        step_len = siode_pkg::StepReset; end_len = 0; use_rk4 = 1'b0;
        clock_now = 0; lvl = '{0, 0, 0};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset configuration and extreme loaded levels.
        begin
            t_epi_item it;
            it.op     = siode_pkg::OP_ADVANCE;
            it.levels = '0;
            pending_items.push_back(it);
            it.op     = siode_pkg::OP_LOAD;
            it.levels = {32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
            pending_items.push_back(it);
            it.op     = siode_pkg::OP_ADVANCE;
            pending_items.push_back(it);
            drain();
        end
        // Directed: maximum rates with both methods.
        run_trajectory(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF, siode_pkg::METHOD_EULER,
                       {32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000}, 3);
        run_trajectory(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF, siode_pkg::METHOD_RK4,
                       {32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}, 3);
        // Directed: a typical epidemic, stepping past its end.
        run_trajectory(32'h0000_8000, 32'h0000_2000, 32'h0000_1000, 32'h0000_4000,
                       32'h0001_0000, siode_pkg::METHOD_RK4,
                       {32'h0000_1000, 32'h0001_0000, 32'h0000_0000}, 6);
        // Directed: zero step keeps time still; smallest step with a zero end.
        run_trajectory(32'h0001_0000, 32'h0000_1000, 32'h0000_1000, 0, 32'h0000_0010,
                       siode_pkg::METHOD_EULER,
                       {32'h0000_1000, 32'h0001_0000, 32'h0000_1000}, 3);
        run_trajectory(0, 0, 0, 1, 0, siode_pkg::METHOD_RK4,
                       {32'hFFFF_0000, 32'h0002_0000, 32'h0000_0001}, 3);

        // Random trajectories, each starting from a load.
        for (int p = 0; p < 42; p++) begin
            idle_mode = p * 3 / 42;
            case ($urandom_range(9))
                0:       h = 32'h7FFF_FFFF;
                1:       h = 1;
                2:       h = $urandom & 32'h7FFF_FFFF;
                default: h = $urandom_range(1, 32'h0000_4000);
            endcase
            run_trajectory(pick_rate(), pick_rate(), pick_rate(), h,
                           ($urandom_range(3) == 0) ? ($urandom & 32'h7FFF_FFFF)
                                                    : $urandom_range(32'h0004_0000),
                           1'($urandom_range(1)),
                           {pick_level(), pick_level(), pick_level()}, 46);
        end

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #40ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/siode_pkg.sv
sv/siode_mul.sv
sv/siode_seq.sv
sv/sirs_ode_integrator_step_unit.sv
tb/tb_sirs_ode_integrator_step_unit.sv
